[hw/rtl/hfd_pkg.sv]
// Shared types and constants of the Huffman tree decoder.
package hfd_pkg;

    // Fixed field widths of the item and result beats.
    localparam int OP_W     = 2;
    localparam int SYM_W    = 8;
    localparam int CLEN_W   = 6;
    localparam int CODE_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int VBC_W    = 48;
    localparam int STATUS_W = 3;

    // Operation codes carried by an input beat.
    typedef enum logic [OP_W-1:0] {
        OP_START  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_DECODE = 2'd2,
        OP_END    = 2'd3
    } op_t;

    // Status codes carried by a result beat.
    typedef enum logic [STATUS_W-1:0] {
        ST_SYMBOL   = 3'd0,
        ST_COMPLETE = 3'd1,
        ST_MISMATCH = 3'd2,
        ST_SHORT    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_L_STEP,
        S_L_NEW,
        S_L_FETCH,
        S_L_SYM,
        S_D_FETCH,
        S_D_BIT,
        S_D_LEAF,
        S_FLUSH
    } state_t;

    // Request from the sequencer to the result buffer.
    typedef struct packed {
        logic             push;
        logic             flush;
        status_t          status;
        logic [SYM_W-1:0] symbol;
    } res_req_t;

endpackage

[hw/rtl/hfd_node_store.sv]
// Node store: one word per tree node, one write port and one registered read port.
module hfd_node_store #(
    parameter int DEPTH  = 512,
    parameter int WORD_W = 26
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WORD_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WORD_W-1:0]        rd_data
);
    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    // Write and registered read; read data holds until the next read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/hfd_result_buffer.sv]
// Result buffer: holds one result back until its last flag is known, then drives the output.
module hfd_result_buffer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hfd_pkg::res_req_t             req,
    output logic                          buf_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [hfd_pkg::STATUS_W-1:0]  m_status,
    output logic [hfd_pkg::SYM_W-1:0]     m_decoded_symbol,
    output logic                          m_last
);
    import hfd_pkg::*;

    logic                pend_valid_reg, pend_valid_next;
    status_t             pend_status_reg, pend_status_next;
    logic [SYM_W-1:0]    pend_sym_reg, pend_sym_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [SYM_W-1:0]    out_sym_reg, out_sym_next;
    logic                out_last_reg, out_last_next;
    logic                out_free;
    logic                take;
    logic                move;

    assign out_free  = !out_valid_reg || m_ready;
    assign buf_ready = !pend_valid_reg || out_free;
    assign take      = (req.push || req.flush) && buf_ready;
    assign move      = take && pend_valid_reg;

    // A new result pushes the held one out; a flush sends the held one as last.
    always_comb begin
        pend_valid_next  = pend_valid_reg;
        pend_status_next = pend_status_reg;
        pend_sym_next    = pend_sym_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_sym_next     = out_sym_reg;
        out_last_next    = out_last_reg;
        if (move) begin
            out_valid_next  = 1'b1;
            out_status_next = pend_status_reg;
            out_sym_next    = pend_sym_reg;
            out_last_next   = req.flush;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (take && req.push) begin
            pend_valid_next  = 1'b1;
            pend_status_next = req.status;
            pend_sym_next    = req.symbol;
        end else if (take) begin
            pend_valid_next = 1'b0;
        end
    end

    // Control flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        pend_status_reg <= pend_status_next;
        pend_sym_reg    <= pend_sym_next;
        out_status_reg  <= out_status_next;
        out_sym_reg     <= out_sym_next;
        out_last_reg    <= out_last_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = out_status_reg;
    assign m_decoded_symbol = out_sym_reg;
    assign m_last           = out_last_reg;

endmodule

[hw/rtl/hfd_walker.sv]
// Sequencer that builds the code tree and walks it one bit per step through the node store.
module hfd_walker #(
    parameter int NODE_DEPTH   = 512,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [hfd_pkg::VBC_W-1:0]             cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [hfd_pkg::OP_W-1:0]              s_operation,
    input  logic [hfd_pkg::SYM_W-1:0]             s_symbol,
    input  logic [hfd_pkg::CLEN_W-1:0]            s_code_length,
    input  logic [hfd_pkg::CODE_W-1:0]            s_code_bits,
    input  logic [hfd_pkg::BYTE_W-1:0]            s_data_byte,
    input  logic                                  buf_ready,
    output hfd_pkg::res_req_t                     res_req,
    output logic                                  mem_wr_en,
    output logic [$clog2(NODE_DEPTH)-1:0]         mem_wr_addr,
    output logic [2*$clog2(NODE_DEPTH)+7:0]       mem_wr_data,
    output logic                                  mem_rd_en,
    output logic [$clog2(NODE_DEPTH)-1:0]         mem_rd_addr,
    input  logic [2*$clog2(NODE_DEPTH)+7:0]       mem_rd_data
);
    import hfd_pkg::*;

    localparam int IW    = $clog2(NODE_DEPTH);
    localparam int CW    = $clog2(NODE_DEPTH + 1);
    localparam int LEN_W = $clog2(MAX_CODE_LEN + 1);

    state_t              state_reg, state_next;
    logic [VBC_W-1:0]    vbc_reg, vbc_next;
    logic [VBC_W-1:0]    bits_reg, bits_next;
    logic                err_reg, err_next;
    logic [CW-1:0]       nodes_reg, nodes_next;
    logic [IW-1:0]       cur_node_reg, cur_node_next;
    logic [IW-1:0]       root_l_reg, root_l_next;
    logic [IW-1:0]       root_r_reg, root_r_next;
    logic [IW-1:0]       node_reg, node_next;
    logic [IW-1:0]       fresh_reg, fresh_next;
    logic [IW-1:0]       cur_l_reg, cur_l_next;
    logic [IW-1:0]       cur_r_reg, cur_r_next;
    logic [SYM_W-1:0]    cur_sym_reg, cur_sym_next;
    logic [LEN_W-1:0]    k_reg, k_next;
    logic [2:0]          bit_idx_reg, bit_idx_next;
    logic [SYM_W-1:0]    sym_reg, sym_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic [BYTE_W-1:0]   byte_reg, byte_next;

    logic [6:0]          clen_ext;
    logic [6:0]          clen_sat;
    logic [6:0]          pos;
    logic                code_bit;
    logic                data_bit;
    logic [IW-1:0]       slot;
    logic [IW-1:0]       nxt;
    logic [IW-1:0]       rd_l;
    logic [IW-1:0]       rd_r;
    logic [SYM_W-1:0]    rd_sym;
    logic                store_full;

    // Decoded pieces of the word coming back from the node store.
    assign rd_l   = mem_rd_data[2*IW+7 -: IW];
    assign rd_r   = mem_rd_data[IW+7 -: IW];
    assign rd_sym = mem_rd_data[SYM_W-1:0];

    // Code length clipped to the longest supported code.
    assign clen_ext = {1'b0, s_code_length};
    assign clen_sat = (clen_ext > 7'(MAX_CODE_LEN)) ? 7'(MAX_CODE_LEN) : clen_ext;

    // The step logic: pick the branch bit and the child it selects, for loads (slot) and decodes (nxt).
    assign pos        = 7'(k_reg) - 7'd1;
    assign code_bit   = (pos < 7'd32) ? code_reg[pos[4:0]] : 1'b0;
    assign data_bit   = byte_reg[bit_idx_reg];
    assign slot       = code_bit ? cur_r_reg : cur_l_reg;
    assign nxt        = data_bit ? cur_r_reg : cur_l_reg;
    assign store_full = (nodes_reg == CW'(NODE_DEPTH));

    assign s_ready = (state_reg == S_IDLE);

    // Next state and datapath control.
    always_comb begin
        state_next    = state_reg;
        vbc_next      = vbc_reg;
        bits_next     = bits_reg;
        err_next      = err_reg;
        nodes_next    = nodes_reg;
        cur_node_next = cur_node_reg;
        root_l_next   = root_l_reg;
        root_r_next   = root_r_reg;
        node_next     = node_reg;
        fresh_next    = fresh_reg;
        cur_l_next    = cur_l_reg;
        cur_r_next    = cur_r_reg;
        cur_sym_next  = cur_sym_reg;
        k_next        = k_reg;
        bit_idx_next  = bit_idx_reg;
        sym_next      = sym_reg;
        code_next     = code_reg;
        byte_next     = byte_reg;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = '0;
        mem_wr_data   = '0;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = '0;
        res_req       = '0;

        if (cfg_we) begin
            vbc_next = cfg_wdata;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    sym_next  = s_symbol;
                    code_next = s_code_bits;
                    byte_next = s_data_byte;
                    unique case (op_t'(s_operation))
                        OP_START: begin
                            root_l_next   = '0;
                            root_r_next   = '0;
                            nodes_next    = CW'(1);
                            cur_node_next = '0;
                            bits_next     = '0;
                            err_next      = 1'b0;
                        end
                        OP_LOAD: begin
                            node_next    = '0;
                            cur_l_next   = root_l_reg;
                            cur_r_next   = root_r_reg;
                            cur_sym_next = '0;
                            k_next       = LEN_W'(clen_sat);
                            if (clen_sat != 7'd0) begin
                                state_next = S_L_STEP;
                            end
                        end
                        OP_DECODE: begin
                            bit_idx_next = 3'd7;
                            if (!err_reg) begin
                                if (cur_node_reg == '0) begin
                                    cur_l_next = root_l_reg;
                                    cur_r_next = root_r_reg;
                                    state_next = S_D_BIT;
                                end else begin
                                    mem_rd_en   = 1'b1;
                                    mem_rd_addr = cur_node_reg;
                                    state_next  = S_D_FETCH;
                                end
                            end
                        end
                        OP_END: begin
                            res_req.push = 1'b1;
                            if (err_reg) begin
                                res_req.status = ST_MISMATCH;
                            end else if (bits_reg < vbc_reg) begin
                                res_req.status = ST_SHORT;
                            end else begin
                                res_req.status = ST_COMPLETE;
                            end
                            state_next = S_FLUSH;
                        end
                    endcase
                end
            end

            // Follow an existing child, or allocate one and link it to its parent; report a full store.
            S_L_STEP: begin
                if (slot != '0) begin
                    node_next   = slot;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = slot;
                    state_next  = S_L_FETCH;
                end else if (store_full) begin
                    res_req.push   = 1'b1;
                    res_req.status = ST_FULL;
                    state_next     = S_FLUSH;
                end else begin
                    fresh_next = IW'(nodes_reg);
                    nodes_next = nodes_reg + CW'(1);
                    if (node_reg == '0) begin
                        if (code_bit) begin
                            root_r_next = IW'(nodes_reg);
                        end else begin
                            root_l_next = IW'(nodes_reg);
                        end
                    end else begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = node_reg;
                        mem_wr_data = code_bit ? {cur_l_reg, IW'(nodes_reg), cur_sym_reg}
                                               : {IW'(nodes_reg), cur_r_reg, cur_sym_reg};
                    end
                    state_next = S_L_NEW;
                end
            end

            // Write the new node empty; on the final bit it takes the symbol at once.
            S_L_NEW: begin
                mem_wr_en    = 1'b1;
                mem_wr_addr  = fresh_reg;
                mem_wr_data  = {{(2*IW){1'b0}}, (k_reg == LEN_W'(1)) ? sym_reg : 8'd0};
                node_next    = fresh_reg;
                cur_l_next   = '0;
                cur_r_next   = '0;
                cur_sym_next = '0;
                k_next       = k_reg - LEN_W'(1);
                state_next   = (k_reg == LEN_W'(1)) ? S_IDLE : S_L_STEP;
            end

            S_L_FETCH: begin
                cur_l_next   = rd_l;
                cur_r_next   = rd_r;
                cur_sym_next = rd_sym;
                k_next       = k_reg - LEN_W'(1);
                state_next   = (k_reg == LEN_W'(1)) ? S_L_SYM : S_L_STEP;
            end

            // The code ended on a node that already existed: give it the symbol.
            S_L_SYM: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = node_reg;
                mem_wr_data = {cur_l_reg, cur_r_reg, sym_reg};
                state_next  = S_IDLE;
            end

            S_D_FETCH: begin
                cur_l_next = rd_l;
                cur_r_next = rd_r;
                state_next = S_D_BIT;
            end

            // Take one data bit, unless the valid-bit count is used up.
            S_D_BIT: begin
                if (bits_reg >= vbc_reg) begin
                    state_next = S_FLUSH;
                end else if (nxt == '0) begin
                    if (buf_ready) begin
                        bits_next      = bits_reg + VBC_W'(1);
                        err_next       = 1'b1;
                        res_req.push   = 1'b1;
                        res_req.status = ST_MISMATCH;
                        state_next     = S_FLUSH;
                    end
                end else begin
                    bits_next   = bits_reg + VBC_W'(1);
                    node_next   = nxt;
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = nxt;
                    state_next  = S_D_LEAF;
                end
            end

            // A node without children is a leaf: emit its symbol and go back to the root; else it becomes current.
            S_D_LEAF: begin
                if (rd_l == '0 && rd_r == '0) begin
                    if (buf_ready) begin
                        res_req.push   = 1'b1;
                        res_req.status = ST_SYMBOL;
                        res_req.symbol = rd_sym;
                        cur_node_next  = '0;
                        cur_l_next     = root_l_reg;
                        cur_r_next     = root_r_reg;
                        bit_idx_next   = bit_idx_reg - 3'd1;
                        state_next     = (bit_idx_reg == 3'd0) ? S_FLUSH : S_D_BIT;
                    end
                end else begin
                    cur_node_next = node_reg;
                    cur_l_next    = rd_l;
                    cur_r_next    = rd_r;
                    bit_idx_next  = bit_idx_reg - 3'd1;
                    state_next    = (bit_idx_reg == 3'd0) ? S_FLUSH : S_D_BIT;
                end
            end

            // Send the held result as the last one of this item.
            S_FLUSH: begin
                res_req.flush = 1'b1;
                if (buf_ready) begin
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            vbc_reg      <= '0;
            bits_reg     <= '0;
            err_reg      <= 1'b0;
            nodes_reg    <= CW'(1);
            cur_node_reg <= '0;
            root_l_reg   <= '0;
            root_r_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            vbc_reg      <= vbc_next;
            bits_reg     <= bits_next;
            err_reg      <= err_next;
            nodes_reg    <= nodes_next;
            cur_node_reg <= cur_node_next;
            root_l_reg   <= root_l_next;
            root_r_reg   <= root_r_next;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge aclk) begin
        node_reg    <= node_next;
        fresh_reg   <= fresh_next;
        cur_l_reg   <= cur_l_next;
        cur_r_reg   <= cur_r_next;
        cur_sym_reg <= cur_sym_next;
        k_reg       <= k_next;
        bit_idx_reg <= bit_idx_next;
        sym_reg     <= sym_next;
        code_reg    <= code_next;
        byte_reg    <= byte_next;
    end

    // The node count stays between one and the store depth.
    a_nodes_range: assert property (@(posedge aclk) disable iff (!aresetn)
        nodes_reg != '0 && nodes_reg <= CW'(NODE_DEPTH))
        else $error("node count out of range");

    // Only allocated nodes other than the root are written in the store.
    a_write_allocated: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> mem_wr_addr != '0 && CW'(mem_wr_addr) < nodes_reg)
        else $error("node store written outside the allocated nodes");

    // Checks that a result is handed over only when the buffer can take it; end and full-store pushes do not test it.
    a_push_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        res_req.push |-> buf_ready)
        else $error("result pushed while the buffer is full");

    // The error flag is raised only together with a mismatch result.
    a_error_reported: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(err_reg) |-> $past(res_req.push && res_req.status == ST_MISMATCH))
        else $error("error flag set without a mismatch result");

endmodule

[hw/rtl/huffman_tree_decoder.sv]
// Top level of the Huffman tree decoder.
// The block takes one item at a time and drops s_ready until that item's work is done; a
// finished result waits in the output register while the next item is taken. A start item
// is handled at once in the idle state. A load steps through every code bit (a read of an
// existing node, or the parent link and the write of a new node), then stores the symbol
// when the code ends on an existing node. A decode byte is accepted, then for every walked
// bit the child is selected and read back to test for a leaf; the current node is fetched
// first when the walk sits inside a code, and the byte ends early when the bit count runs
// out, and the item closes with a flush. An end item pushes its status and then flushes.
// All of this sequencing comes from the single read and write port
// of the node store, which every tree step goes through. No clearing pass is needed after
// reset: the root's links live in flip-flops and every other node is written when allocated.
module huffman_tree_decoder #(
    parameter int NODE_DEPTH   = 512,
    parameter int MAX_CODE_LEN = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [hfd_pkg::VBC_W-1:0]         cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [hfd_pkg::OP_W-1:0]          s_operation,
    input  logic [hfd_pkg::SYM_W-1:0]         s_symbol,
    input  logic [hfd_pkg::CLEN_W-1:0]        s_code_length,
    input  logic [hfd_pkg::CODE_W-1:0]        s_code_bits,
    input  logic [hfd_pkg::BYTE_W-1:0]        s_data_byte,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [hfd_pkg::STATUS_W-1:0]      m_status,
    output logic [hfd_pkg::SYM_W-1:0]         m_decoded_symbol,
    output logic                              m_last
);
    import hfd_pkg::*;

    localparam int IW     = $clog2(NODE_DEPTH);
    localparam int WORD_W = 2 * IW + SYM_W;

    res_req_t          res_req;
    logic              buf_ready;
    logic              mem_wr_en;
    logic [IW-1:0]     mem_wr_addr;
    logic [WORD_W-1:0] mem_wr_data;
    logic              mem_rd_en;
    logic [IW-1:0]     mem_rd_addr;
    logic [WORD_W-1:0] mem_rd_data;

    // Tree builder and walker.
    hfd_walker #(
        .NODE_DEPTH   (NODE_DEPTH),
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_walker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_symbol      (s_symbol),
        .s_code_length (s_code_length),
        .s_code_bits   (s_code_bits),
        .s_data_byte   (s_data_byte),
        .buf_ready     (buf_ready),
        .res_req       (res_req),
        .mem_wr_en     (mem_wr_en),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_en     (mem_rd_en),
        .mem_rd_addr   (mem_rd_addr),
        .mem_rd_data   (mem_rd_data)
    );

    // Node links and symbols.
    hfd_node_store #(
        .DEPTH  (NODE_DEPTH),
        .WORD_W (WORD_W)
    ) u_node_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Result holding and output register.
    hfd_result_buffer u_result_buffer (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .req              (res_req),
        .buf_ready        (buf_ready),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_decoded_symbol (m_decoded_symbol),
        .m_last           (m_last)
    );

endmodule
